// ----- design/topo_pkg.sv -----
// Shared types for the topological order engine.
// Word formats on the command and result ports, sequencer states, degree ops.
// No dependencies.
package topo_pkg;

  localparam int IDX_W = 6;

  typedef struct packed {
    logic [IDX_W-1:0] dep_index;
    logic             has_dep;
    logic             last_of_task;
    logic             last_of_graph;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] task_index;
    logic             no_task;
    logic             cycle_found;
    logic             overflow;
    logic             last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SEED,
    S_POP,
    S_FETCH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic {
    OP_CHECK,
    OP_DECR
  } deg_op_t;

endpackage

// ----- design/topo_degree.sv -----
// In-degree store of the topological order engine: one synchronous memory,
// read-modify-write, with the last decrement forwarded. Depends on topo_pkg.
module topo_degree #(
  parameter int MAX_TASKS   = 64,
  parameter int MAX_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_TASKS)-1:0] wr_idx,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0] wr_val,
  input  logic                         req_valid,
  input  topo_pkg::deg_op_t            req_op,
  input  logic [$clog2(MAX_TASKS)-1:0] req_idx,
  output logic                         pending,
  output logic                         push_valid,
  output logic [$clog2(MAX_TASKS)-1:0] push_idx
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int DW = $clog2(MAX_ENTRIES + 1);

  logic [DW-1:0] mem [MAX_TASKS];
  logic [DW-1:0] rd_q;

  logic              stg_v;
  topo_pkg::deg_op_t stg_op;
  logic [TW-1:0]     stg_idx;

  logic          fwd_v;
  logic [TW-1:0] fwd_idx;
  logic [DW-1:0] fwd_val;

  logic [DW-1:0] cur;
  logic          dec_we;
  logic [DW-1:0] dec_val;

  always_comb begin
    cur = (fwd_v && fwd_idx == stg_idx) ? fwd_val : rd_q;
    dec_we = stg_v && stg_op == topo_pkg::OP_DECR && cur != '0;
    dec_val = cur - DW'(1);
    push_valid = stg_v && ((stg_op == topo_pkg::OP_CHECK && rd_q == '0) ||
                           (dec_we && dec_val == '0));
    push_idx = stg_idx;
    pending = stg_v;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_val;
    end else if (dec_we) begin
      mem[stg_idx] <= dec_val;
    end
    rd_q <= mem[req_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= 1'b0;
      fwd_v <= 1'b0;
    end else begin
      stg_v <= req_valid;
      fwd_v <= dec_we;
    end
  end

  always_ff @(posedge clk) begin
    stg_op <= req_op;
    stg_idx <= req_idx;
    fwd_idx <= stg_idx;
    fwd_val <= dec_val;
  end

endmodule

// ----- design/topological_order_engine.sv -----
// Topological order engine top level: load sequencer, entry store, ready queue.
// Depends on topo_pkg and topo_degree.
//
// Command words are loaded one per cycle while busy is low; each names one
// dependency of the current task or marks a task without dependencies. The
// word with last_of_graph starts the sort and raises busy. The sort first
// walks the in-degree memory once, then for each task taken from the ready
// queue scans every loaded entry, one entry per cycle through a three-stage
// read-modify-write path. Each ordered task is shown on result for one cycle
// with result_valid, one such word per task, the last one flagged with last
// plus cycle and overflow status; an empty order gives a single word with
// no_task set. The receiver must take every word as it appears. busy falls
// in the cycle after the last word.
module topological_order_engine #(
  parameter int MAX_TASKS   = 64,
  parameter int MAX_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  topo_pkg::in_word_t  item,
  output logic                busy,
  output logic                result_valid,
  output topo_pkg::out_word_t result
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int TCW = $clog2(MAX_TASKS + 1);
  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int IW  = topo_pkg::IDX_W;
  localparam int CW  = (TW > IW) ? TW : IW;

  topo_pkg::state_t state, state_next;

  logic [TCW-1:0] task_count;
  logic [ECW-1:0] entry_count;
  logic [ECW-1:0] cur_total;
  logic           overflow_seen;
  logic [TCW-1:0] head;
  logic [TCW-1:0] tail;
  logic [TCW-1:0] seed_i;
  logic [ECW-1:0] scan_e;
  logic           s1_v;
  logic           pend_v;
  logic [TW-1:0]  cur_task;

  logic [IW+TW-1:0] ent_mem [MAX_ENTRIES];
  logic [IW+TW-1:0] ent_q;
  logic [TW-1:0]    q_mem [MAX_TASKS];
  logic [TW-1:0]    q_q;

  logic           accept;
  logic           load_ok;
  logic           ent_room;
  logic           ent_we;
  logic           task_end;
  logic [ECW-1:0] total_new;
  logic [IW-1:0]  ent_target;
  logic [TW-1:0]  ent_owner;
  logic           hit;
  logic           seed_issue;
  logic           scan_issue;
  logic [CW-1:0]  task_wide;

  logic              req_valid;
  topo_pkg::deg_op_t req_op;
  logic [TW-1:0]     req_idx;
  logic              deg_pending;
  logic              push_valid;
  logic [TW-1:0]     push_idx;

  always_comb begin
    accept = start && state == topo_pkg::S_LOAD;
    load_ok = task_count != TCW'(MAX_TASKS);
    ent_room = entry_count != ECW'(MAX_ENTRIES);
    ent_we = accept && load_ok && item.has_dep && ent_room;
    task_end = accept && load_ok && (item.last_of_task || item.last_of_graph);
    total_new = cur_total + ECW'(ent_we);
    ent_target = ent_q[IW+TW-1:TW];
    ent_owner = ent_q[TW-1:0];
    hit = s1_v && (CW'(ent_target) == CW'(cur_task));
    task_wide = CW'(cur_task);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      topo_pkg::S_LOAD: begin
        if (accept && item.last_of_graph) state_next = topo_pkg::S_SEED;
      end
      topo_pkg::S_SEED: begin
        if (seed_i == task_count && !deg_pending) state_next = topo_pkg::S_POP;
      end
      topo_pkg::S_POP: begin
        state_next = (head != tail) ? topo_pkg::S_FETCH : topo_pkg::S_DONE;
      end
      topo_pkg::S_FETCH: begin
        state_next = topo_pkg::S_SCAN;
      end
      topo_pkg::S_SCAN: begin
        if (scan_e == entry_count && !s1_v && !deg_pending) state_next = topo_pkg::S_POP;
      end
      topo_pkg::S_DONE: begin
        state_next = topo_pkg::S_LOAD;
      end
      default: state_next = topo_pkg::S_LOAD;
    endcase
  end

  // outputs and issue controls
  always_comb begin
    busy = state != topo_pkg::S_LOAD;
    seed_issue = state == topo_pkg::S_SEED && seed_i != task_count;
    scan_issue = state == topo_pkg::S_SCAN && scan_e != entry_count;
    req_valid = seed_issue || (state == topo_pkg::S_SCAN && hit);
    req_op = (state == topo_pkg::S_SEED) ? topo_pkg::OP_CHECK : topo_pkg::OP_DECR;
    req_idx = (state == topo_pkg::S_SEED) ? seed_i[TW-1:0] : ent_owner;
    result_valid = (state == topo_pkg::S_FETCH && pend_v) || state == topo_pkg::S_DONE;
    result.task_index = task_wide[IW-1:0];
    result.no_task = 1'b0;
    result.cycle_found = 1'b0;
    result.overflow = 1'b0;
    result.last = 1'b0;
    if (state == topo_pkg::S_DONE) begin
      result.task_index = pend_v ? task_wide[IW-1:0] : '0;
      result.no_task = !pend_v;
      result.cycle_found = head < task_count;
      result.overflow = overflow_seen;
      result.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= topo_pkg::S_LOAD;
      task_count <= '0;
      entry_count <= '0;
      cur_total <= '0;
      overflow_seen <= 1'b0;
      head <= '0;
      tail <= '0;
      seed_i <= '0;
      scan_e <= '0;
      s1_v <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      state <= state_next;
      s1_v <= scan_issue;
      if (push_valid) tail <= tail + TCW'(1);
      unique case (state)
        topo_pkg::S_LOAD: begin
          if (accept) begin
            if (!load_ok || (item.has_dep && !ent_room)) overflow_seen <= 1'b1;
            if (ent_we) entry_count <= entry_count + ECW'(1);
            if (task_end) begin
              task_count <= task_count + TCW'(1);
              cur_total <= '0;
            end else if (load_ok) begin
              cur_total <= total_new;
            end
            if (item.last_of_graph) begin
              seed_i <= '0;
              head <= '0;
              tail <= '0;
              pend_v <= 1'b0;
            end
          end
        end
        topo_pkg::S_SEED: begin
          if (seed_issue) seed_i <= seed_i + TCW'(1);
        end
        topo_pkg::S_POP: begin
          if (head != tail) head <= head + TCW'(1);
        end
        topo_pkg::S_FETCH: begin
          pend_v <= 1'b1;
          scan_e <= '0;
        end
        topo_pkg::S_SCAN: begin
          if (scan_issue) scan_e <= scan_e + ECW'(1);
        end
        topo_pkg::S_DONE: begin
          task_count <= '0;
          entry_count <= '0;
          cur_total <= '0;
          overflow_seen <= 1'b0;
          head <= '0;
          tail <= '0;
          pend_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == topo_pkg::S_FETCH) cur_task <= q_q;
  end

  // entry store: {target, owner}
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[entry_count[EW-1:0]] <= {item.dep_index, task_count[TW-1:0]};
    ent_q <= ent_mem[scan_e[EW-1:0]];
  end

  // ready queue
  always_ff @(posedge clk) begin
    if (push_valid) q_mem[tail[TW-1:0]] <= push_idx;
    q_q <= q_mem[head[TW-1:0]];
  end

  topo_degree #(
    .MAX_TASKS  (MAX_TASKS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_degree (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (task_end),
    .wr_idx    (task_count[TW-1:0]),
    .wr_val    (total_new),
    .req_valid (req_valid),
    .req_op    (req_op),
    .req_idx   (req_idx),
    .pending   (deg_pending),
    .push_valid(push_valid),
    .push_idx  (push_idx)
  );

  a_no_task_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.no_task |-> result.last)
    else $error("empty order word not marked last");

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("ready queue read past its tail");

  a_tail_le_tasks: assert property (@(posedge clk) disable iff (rst)
    tail <= task_count)
    else $error("more tasks queued than loaded");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(result_valid && result.last))
    else $error("busy dropped without a final word");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("word issued after the final word");

endmodule

// ----- bench/testbench.sv -----
// Testbench for topological_order_engine: streams task graphs, checks every ordered task word.
// Depends on topo_pkg and the engine RTL; carries its own Kahn-sort model of the block.
`timescale 1ns / 100ps

module testbench;

  localparam int TASK_CAP   = 64;
  localparam int ENTRY_CAP  = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 300;
  localparam int RANDOM_WORDS = 170;

  typedef struct {
    topo_pkg::in_word_t  w;
    bit                  typed;
    topo_pkg::out_word_t want;
  } step_row_t;

  localparam topo_pkg::out_word_t NO_WORD = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  topo_pkg::in_word_t  item = '0;
  logic                busy;
  logic                result_valid;
  topo_pkg::out_word_t result;

  topological_order_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  always #5 clk = ~clk;

  // model state
  logic [5:0] ent_target [ENTRY_CAP];
  logic [5:0] ent_owner  [ENTRY_CAP];
  logic [8:0] dep_total  [TASK_CAP];
  logic [8:0] indeg      [TASK_CAP];
  logic [5:0] ready      [TASK_CAP];
  logic [6:0] q_head, q_tail, n_tasks, n_emitted;
  logic [8:0] n_entries;
  logic       dropped;

  topo_pkg::out_word_t sort_out[$];
  topo_pkg::out_word_t expected_order[$];

  int errors = 0;
  int words_sent = 0;
  int graphs_sent = 0;
  int words_checked = 0;
  int cycle_graphs = 0;
  int overflow_graphs = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;

  // lone tasks, self and unknown dependencies, duplicates, filler entries, partial cycle
  step_row_t directed_rows [17] = '{
    '{'{6'd0,  1'b0, 1'b1, 1'b1}, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{6'd0,  1'b1, 1'b1, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{6'd63, 1'b1, 1'b0, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{6'd21, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd0,  1'b1, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd1,  1'b1, 1'b0, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd42, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd2,  1'b1, 1'b0, 1'b1}, 1'b0, NO_WORD},
    '{'{6'd2,  1'b1, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd1,  1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{'{6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd2,  1'b1, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd1,  1'b1, 1'b1, 1'b0}, 1'b0, NO_WORD},
    '{'{6'd0,  1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{'{6'd63, 1'b0, 1'b1, 1'b1}, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 1'b1}}
  };

  function automatic void clear_model();
    foreach (ent_target[e]) begin
      ent_target[e] = '0;
      ent_owner[e] = '0;
    end
    foreach (dep_total[i]) begin
      dep_total[i] = '0;
      indeg[i] = '0;
      ready[i] = '0;
    end
    q_head = '0;
    q_tail = '0;
    n_tasks = '0;
    n_emitted = '0;
    n_entries = '0;
    dropped = 1'b0;
  endfunction

  function automatic void queue_ready(logic [5:0] t);
    if (q_tail < TASK_CAP) begin
      ready[q_tail[5:0]] = t;
      q_tail++;
    end
  endfunction

  // loads one command word; on graph end runs the sort into sort_out
  function automatic void load_and_sort(topo_pkg::in_word_t w);
    logic [5:0]          t;
    logic [5:0]          o;
    topo_pkg::out_word_t res;
    bit                  cyc;
    sort_out.delete();
    if (n_tasks >= TASK_CAP) begin
      dropped = 1'b1;
    end else begin
      if (w.has_dep) begin
        if (n_entries >= ENTRY_CAP) begin
          dropped = 1'b1;
        end else begin
          ent_target[n_entries[7:0]] = w.dep_index;
          ent_owner[n_entries[7:0]] = n_tasks[5:0];
          n_entries++;
          dep_total[n_tasks[5:0]]++;
        end
      end
      if (w.last_of_task || w.last_of_graph) begin
        n_tasks++;
        if (n_tasks < TASK_CAP) dep_total[n_tasks[5:0]] = '0;
      end
    end
    if (!w.last_of_graph) return;

    q_head = '0;
    q_tail = '0;
    n_emitted = '0;
    for (int i = 0; i < n_tasks; i++) begin
      indeg[6'(i)] = dep_total[6'(i)];
      if (dep_total[6'(i)] == 0) queue_ready(6'(i));
    end
    while (q_head < q_tail) begin
      t = ready[q_head[5:0]];
      q_head++;
      res = '0;
      res.task_index = t;
      sort_out = {sort_out, res};
      n_emitted++;
      for (int e = 0; e < n_entries; e++) begin
        if (ent_target[8'(e)] == t) begin
          o = ent_owner[8'(e)];
          if (indeg[o] > 0) begin
            indeg[o]--;
            if (indeg[o] == 0) queue_ready(o);
          end
        end
      end
    end

    cyc = (n_emitted < n_tasks);
    if (sort_out.size() == 0) begin
      res = '0;
      res.no_task = 1'b1;
      sort_out = {sort_out, res};
    end
    sort_out[sort_out.size()-1].cycle_found = cyc;
    sort_out[sort_out.size()-1].overflow = dropped;
    sort_out[sort_out.size()-1].last = 1'b1;
    if (cyc) cycle_graphs++;
    if (dropped) overflow_graphs++;
    graphs_sent++;

    n_tasks = '0;
    n_entries = '0;
    n_emitted = '0;
    q_head = '0;
    q_tail = '0;
    dropped = 1'b0;
    dep_total[0] = '0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_word(input topo_pkg::in_word_t w, input bit typed = 1'b0,
                           input topo_pkg::out_word_t want = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    load_and_sort(w);
    if (typed) expected_order = {expected_order, want};
    else foreach (sort_out[i]) expected_order = {expected_order, sort_out[i]};
    words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_order.size() != 0) @(posedge clk);
  endtask

  // well-formed graphs name only earlier tasks; noisy ones add self, forward and unknown names
  task automatic send_graph(input int tasks, input int min_deps, input int max_deps,
                            input bit noisy);
    topo_pkg::in_word_t w;
    int deps;
    bit stray;
    for (int k = 0; k < tasks; k++) begin
      deps = (k == 0) ? 0 : $urandom_range(min_deps, max_deps);
      if (noisy && $urandom_range(0, 2) == 0) deps = $urandom_range(1, 3);
      if (deps == 0) begin
        w.dep_index = 6'($urandom_range(0, 63));
        w.has_dep = 1'b0;
        w.last_of_task = 1'b1;
        w.last_of_graph = (k == tasks - 1);
        if (w.last_of_graph) w.last_of_task = 1'($urandom_range(0, 1));
        send_word(w);
      end else begin
        for (int d = 0; d < deps; d++) begin
          stray = noisy && (k == 0 || $urandom_range(0, 3) == 0);
          if (stray) w.dep_index = ($urandom_range(0, 1) == 0) ? 6'(k) : 6'($urandom_range(0, 63));
          else w.dep_index = 6'($urandom_range(0, k - 1));
          w.has_dep = ($urandom_range(0, 7) != 0);
          w.last_of_task = (d == deps - 1);
          w.last_of_graph = (k == tasks - 1) && (d == deps - 1);
          if (w.last_of_graph) w.last_of_task = 1'($urandom_range(0, 1));
          send_word(w);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    topo_pkg::out_word_t want;
    if (!rst && result_valid) begin
      if (expected_order.size() == 0) begin
        $error("result word with none expected: task_index %0d", result.task_index);
        errors++;
      end else begin
        want = expected_order.pop_front();
        check_field("task_index", want.task_index, result.task_index);
        check_field("no_task", want.no_task, result.no_task);
        check_field("cycle_found", want.cycle_found, result.cycle_found);
        check_field("overflow", want.overflow, result.overflow);
        check_field("last", want.last, result.last);
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int size;
    clear_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_word(directed_rows[r].w, directed_rows[r].typed, directed_rows[r].want);

    drain_results();
    while (words_sent < RANDOM_WORDS + 17) begin
      if ($urandom_range(0, 5) == 0) drain_results();
      burst = ($urandom_range(0, 3) == 0);
      size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      send_graph(size, 0, 4, $urandom_range(0, 3) == 0);
    end
    burst = 1'b0;
    send_graph(70, 0, 1, 1'b0);

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("%0d command words in %0d graphs, %0d result words checked",
             words_sent, graphs_sent, words_checked);
    $display("%0d graphs left tasks unordered, %0d dropped tasks or entries",
             cycle_graphs, overflow_graphs);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/topo_pkg.sv
design/topo_degree.sv
design/topological_order_engine.sv
bench/testbench.sv
